[rtl/assert_macros.svh]
// assertion macros shared by the rtl modules
// no dependencies; assertions drop out under SYNTHESIS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spq assertion failed");
`define SPQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("spq assertion failed");
`else
`define SPQ_ASSERT(label, clk, rst_n, prop)
`define SPQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[rtl/spq_pkg.sv]
// types, constants and codes of the sorted priority queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH    = 16;
    localparam int TAG_BITS = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_DRAIN = 2'd1,
        ACT_LIST  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_FULL   = 2'd1,
        ST_ENTRY  = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_HEAD,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_STATUS
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [7:0]  req_priority;
        logic [15:0] req_tag;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] out_tag;
        logic [7:0]  out_priority;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]          prio;
        logic [TAG_BITS-1:0] tag;
    } t_slot;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res_req;

endpackage

`default_nettype wire

[rtl/spq_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
    parameter int WIDTH   = 24,
    parameter int DEPTH_P = 16,
    parameter int AW      = $clog2(DEPTH_P)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH_P];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/spq_seq.sv]
// sequencer of the sorted priority queue: insert walk, emit walk, status
// depends on spq_pkg, spq_ram and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spq_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire spq_pkg::t_in_item i_in_item,
    input  wire logic             i_res_free,
    output spq_pkg::t_res_req     o_res
);

    spq_pkg::t_state              r_state, n_state;
    logic [spq_pkg::CNT_W-1:0]    r_count, n_count;
    logic [spq_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [7:0]                   r_prio, n_prio;
    logic [spq_pkg::TAG_BITS-1:0] r_tag, n_tag;
    logic                         r_drain, n_drain;
    spq_pkg::t_status             r_status, n_status;

    logic                         w_we, w_re, w_fire, w_last;
    logic [spq_pkg::IDX_W-1:0]    w_waddr, w_raddr;
    spq_pkg::t_slot               w_wdata, w_rdata;

    spq_ram #(
        .WIDTH   ($bits(spq_pkg::t_slot)),
        .DEPTH_P (spq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_ready = (r_state == spq_pkg::S_IDLE);
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_last     = (r_idx == spq_pkg::IDX_W'(r_count - 1'b1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_prio   <= n_prio;
        r_tag    <= n_tag;
        r_drain  <= n_drain;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_prio   = r_prio;
        n_tag    = r_tag;
        n_drain  = r_drain;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wdata  = w_rdata;
        w_re     = 1'b0;
        w_raddr  = r_idx;
        o_res    = '0;
        unique case (r_state)
            spq_pkg::S_IDLE: begin
                if (w_fire) begin
                    n_prio = i_in_item.req_priority;
                    n_tag  = spq_pkg::TAG_BITS'(i_in_item.req_tag);
                    unique case (i_in_item.action)
                        spq_pkg::ACT_ADD: begin
                            if (r_count == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
                                n_status = spq_pkg::ST_FULL;
                                n_state  = spq_pkg::S_STATUS;
                            end else if (r_count == '0) begin
                                w_we         = 1'b1;
                                w_waddr      = '0;
                                w_wdata.prio = i_in_item.req_priority;
                                w_wdata.tag  = spq_pkg::TAG_BITS'(i_in_item.req_tag);
                                n_count      = r_count + 1'b1;
                                n_status     = spq_pkg::ST_ACCEPT;
                                n_state      = spq_pkg::S_STATUS;
                            end else begin
                                n_idx   = spq_pkg::IDX_W'(r_count - 1'b1);
                                n_state = spq_pkg::S_INS_RD;
                            end
                        end
                        spq_pkg::ACT_DRAIN, spq_pkg::ACT_LIST: begin
                            n_drain = (i_in_item.action == spq_pkg::ACT_DRAIN);
                            if (r_count == '0) begin
                                n_status = spq_pkg::ST_EMPTY;
                                n_state  = spq_pkg::S_STATUS;
                            end else begin
                                n_idx   = '0;
                                n_state = spq_pkg::S_EMIT_RD;
                            end
                        end
                        spq_pkg::ACT_NONE: begin
                            n_state = spq_pkg::S_IDLE;
                        end
                        default: begin
                            n_state = spq_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            spq_pkg::S_INS_RD: begin
                w_re    = 1'b1;
                n_state = spq_pkg::S_INS_CMP;
            end
            spq_pkg::S_INS_CMP: begin
                w_we    = 1'b1;
                w_waddr = r_idx + 1'b1;
                if (w_rdata.prio >= r_prio) begin
                    w_wdata = w_rdata;
                    if (r_idx == '0) begin
                        n_state = spq_pkg::S_INS_HEAD;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = spq_pkg::S_INS_RD;
                    end
                end else begin
                    w_wdata.prio = r_prio;
                    w_wdata.tag  = r_tag;
                    n_count      = r_count + 1'b1;
                    n_status     = spq_pkg::ST_ACCEPT;
                    n_state      = spq_pkg::S_STATUS;
                end
            end
            spq_pkg::S_INS_HEAD: begin
                w_we         = 1'b1;
                w_waddr      = '0;
                w_wdata.prio = r_prio;
                w_wdata.tag  = r_tag;
                n_count      = r_count + 1'b1;
                n_status     = spq_pkg::ST_ACCEPT;
                n_state      = spq_pkg::S_STATUS;
            end
            spq_pkg::S_EMIT_RD: begin
                w_re    = 1'b1;
                n_state = spq_pkg::S_EMIT_OUT;
            end
            spq_pkg::S_EMIT_OUT: begin
                if (i_res_free) begin
                    o_res.valid             = 1'b1;
                    o_res.item.status       = spq_pkg::ST_ENTRY;
                    o_res.item.out_tag      = 16'(w_rdata.tag);
                    o_res.item.out_priority = w_rdata.prio;
                    o_res.item.last         = w_last;
                    if (w_last) begin
                        if (r_drain) begin
                            n_count = '0;
                        end
                        n_state = spq_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = spq_pkg::S_EMIT_RD;
                    end
                end
            end
            spq_pkg::S_STATUS: begin
                if (i_res_free) begin
                    o_res.valid       = 1'b1;
                    o_res.item.status = r_status;
                    o_res.item.last   = 1'b1;
                    n_state           = spq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
    `SPQ_ASSERT(a_res_state, i_clk, i_rst_n, o_res.valid |-> (r_state == spq_pkg::S_EMIT_OUT || r_state == spq_pkg::S_STATUS))
    `SPQ_ASSERT(a_full_reject, i_clk, i_rst_n, (w_fire && i_in_item.action == spq_pkg::ACT_ADD && r_count == spq_pkg::CNT_W'(spq_pkg::DEPTH)) |=> (r_state == spq_pkg::S_STATUS && r_status == spq_pkg::ST_FULL && $stable(r_count)))
    `SPQ_ASSERT(a_insert_grows, i_clk, i_rst_n, (r_state == spq_pkg::S_INS_HEAD) |=> (r_count == $past(r_count) + 1'b1))

endmodule

`default_nettype wire

[rtl/sorted_priority_queue_unit.sv]
// top level of the sorted priority queue: sequencer plus result register
// depends on spq_pkg and spq_seq
//
// input channel: i_in_valid / o_in_ready with i_in_item (action, priority, tag)
// output channel: o_out_valid / i_out_ready with o_out_item
// an add walks the list from the tail through the slot memory, one stored
// entry at a time (read, then compare and shift); its status item passes
// the status state on an empty or full queue straight after acceptance,
// after the walk when k of the stored entries move, or after the walk and
// the head write when all k move, and is then registered
// a drain or list of n entries reads each entry through the registered memory
// read, then registers it as an item; an empty queue gives one empty item
// o_in_ready is high only while the sequencer idles, so the next item can
// be taken at the earliest in the cycle after the last result of the previous
// one is registered, while that result may still wait in the output register
// a stalled receiver holds the output register and the sequencer waits
// reset clears the entry count and the output valid flag; slot contents are
// left as they are and are never read before being written
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire spq_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output spq_pkg::t_out_item     o_out_item
);

    spq_pkg::t_res_req  w_res;
    logic               w_free;
    logic               r_out_valid;
    spq_pkg::t_out_item r_out_item;

    assign w_free = !r_out_valid || i_out_ready;

    spq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_res_free (w_free),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_out_item <= w_res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire
